### hdl/swdt_pkg.sv
`timescale 1ns / 1ps

package swdt_pkg;

  // Default build values
  localparam int TIMER_WIDTH_DEF = 10;
  localparam int LINE_COUNT_DEF  = 3;

  // Field widths
  localparam int TIME_W  = 10;
  localparam int DEV_W   = 8;
  localparam int LINES_W = 3;
  localparam int SHIFT_W = 16;
  localparam int BCNT_W  = 4;

  // APB register file
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Register reset values
  localparam logic [DEV_W-1:0]  RST_DEVICE_ADDRESS = 8'h72;
  localparam logic [TIME_W-1:0] RST_START_TIME     = 10'd20;
  localparam logic [TIME_W-1:0] RST_END_TIME       = 10'd20;
  localparam logic [TIME_W-1:0] RST_SHORT_TIME     = 10'd20;
  localparam logic [TIME_W-1:0] RST_LONG_TIME      = 10'd40;
  localparam logic [TIME_W-1:0] RST_ACK_WINDOW     = 10'd512;
  localparam logic [TIME_W-1:0] RST_DETECT_HIGH    = 10'd120;
  localparam logic [TIME_W-1:0] RST_DETECT_LOW     = 10'd300;

  // Bits per transfer group (address byte, command byte)
  localparam logic [BCNT_W-1:0] BITS_PER_GROUP = 4'd8;

  typedef enum logic [2:0] {
    REG_DEVICE_ADDRESS = 3'd0,
    REG_START_TIME     = 3'd1,
    REG_END_TIME       = 3'd2,
    REG_SHORT_TIME     = 3'd3,
    REG_LONG_TIME      = 3'd4,
    REG_ACK_WINDOW     = 3'd5,
    REG_DETECT_HIGH    = 3'd6,
    REG_DETECT_LOW     = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SEND = 2'd1,
    ACT_INIT = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_DHIGH   = 4'd1,
    PH_DLOW    = 4'd2,
    PH_START1  = 4'd3,
    PH_ADDR    = 4'd4,
    PH_EOS     = 4'd5,
    PH_START2  = 4'd6,
    PH_CMD     = 4'd7,
    PH_ACKWAIT = 4'd8,
    PH_ACKWIN  = 4'd9,
    PH_STOP    = 4'd10
  } phase_t;

  typedef struct packed {
    logic [DEV_W-1:0]  device_address;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] short_time;
    logic [TIME_W-1:0] long_time;
    logic [TIME_W-1:0] ack_window;
    logic [TIME_W-1:0] detect_high_time;
    logic [TIME_W-1:0] detect_low_time;
  } cfg_t;

endpackage

### hdl/swdt_in_if.sv
`timescale 1ns / 1ps

interface swdt_in_if;
  import swdt_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [1:0] channel;
  logic       want_ack;
  logic [1:0] reg_address;
  logic [4:0] data;
  logic       line_sample;

  modport source (
    output valid, action, channel, want_ack, reg_address, data, line_sample,
    input  ready
  );

  modport sink (
    input  valid, action, channel, want_ack, reg_address, data, line_sample,
    output ready
  );
endinterface

### hdl/swdt_out_if.sv
`timescale 1ns / 1ps

interface swdt_out_if;
  import swdt_pkg::*;

  logic               valid;
  logic               ready;
  logic [LINES_W-1:0] line_levels;
  logic [LINES_W-1:0] drive_mask;
  logic               busy_res;
  logic               done_res;
  logic               ack_valid;
  logic               ack_level;
  logic               rejected;

  modport source (
    output valid, line_levels, drive_mask, busy_res, done_res, ack_valid, ack_level,
           rejected,
    input  ready
  );

  modport sink (
    input  valid, line_levels, drive_mask, busy_res, done_res, ack_valid, ack_level,
           rejected,
    output ready
  );
endinterface

### hdl/swdt_core.sv
`timescale 1ns / 1ps

module swdt_core #(
  parameter int TIMER_WIDTH = swdt_pkg::TIMER_WIDTH_DEF,
  parameter int LINE_COUNT  = swdt_pkg::LINE_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  swdt_pkg::cfg_t cfg,
  swdt_in_if.sink        in_ch,
  swdt_out_if.source     out_ch
);
  import swdt_pkg::*;

  localparam int                     SAT_W   = 17;
  localparam logic [SAT_W-1:0]       TMAX    = SAT_W'((1 << TIMER_WIDTH) - 1);
  localparam logic [2:0]             LC      = 3'(LINE_COUNT);

  // Clamp a register duration to 1..TMAX
  function automatic logic [TIMER_WIDTH-1:0] dur(input logic [TIME_W-1:0] v);
    logic [SAT_W-1:0] w;
    w = SAT_W'(v);
    if (w == '0) w = SAT_W'(1);
    if (w > TMAX) w = TMAX;
    return w[TIMER_WIDTH-1:0];
  endfunction

  function automatic logic [LINE_COUNT-1:0] line_mask(input logic [1:0] sel);
    logic [LINE_COUNT-1:0] m;
    for (int i = 0; i < LINE_COUNT; i++) m[i] = (sel == 2'(i));
    return m;
  endfunction

  // Input stage
  logic       s1_valid;
  logic [1:0] s1_action;
  logic [1:0] s1_channel;
  logic       s1_want_ack;
  logic [1:0] s1_reg_address;
  logic [4:0] s1_data;
  logic       s1_line_sample;
  logic       adv;

  // Sequencer state
  phase_t                 phase, phase_next;
  logic [TIMER_WIDTH-1:0] time_left, time_next, time_dec;
  logic [BCNT_W-1:0]      bits_left, bits_next, bits_dec;
  logic                   half_cell, half_next;
  logic [SHIFT_W-1:0]     shift_bits, shift_next, shift_shl;
  logic [1:0]             active_line, line_next;
  logic                   ack_requested, ackreq_next;
  logic [LINE_COUNT-1:0]  levels, levels_next;
  logic [LINE_COUNT-1:0]  drives, drives_next;
  logic [LINE_COUNT-1:0]  cur_mask, send_mask;
  logic                   busy, chan_bad;
  logic                   done_f, ack_v, ack_l, rej_f;

  // Result register
  logic               out_valid;
  logic [LINES_W-1:0] res_levels, res_drives;
  logic               res_busy, res_done, res_ack_v, res_ack_l, res_rej;

  assign adv          = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || adv;

  assign time_dec  = time_left - 1'b1;
  assign bits_dec  = bits_left - 1'b1;
  assign shift_shl = {shift_bits[SHIFT_W-2:0], 1'b0};
  assign cur_mask  = line_mask(active_line);
  assign send_mask = line_mask(s1_channel);
  assign busy      = (phase != PH_IDLE);
  assign chan_bad  = ({1'b0, s1_channel} >= LC);

  always_comb begin
    phase_next  = phase;
    time_next   = time_left;
    bits_next   = bits_left;
    half_next   = half_cell;
    shift_next  = shift_bits;
    line_next   = active_line;
    ackreq_next = ack_requested;
    levels_next = levels;
    drives_next = drives;
    done_f      = 1'b0;
    ack_v       = 1'b0;
    ack_l       = 1'b0;
    rej_f       = 1'b0;

    unique case (s1_action)
      ACT_TICK: begin
        if (busy) begin
          time_next = time_dec;
          if (time_dec == '0) begin
            unique case (phase)
              PH_DHIGH: begin
                levels_next = '0;
                phase_next  = PH_DLOW;
                time_next   = dur(cfg.detect_low_time);
              end
              PH_DLOW: begin
                levels_next = '1;
                phase_next  = PH_IDLE;
                done_f      = 1'b1;
              end
              PH_START1, PH_START2: begin
                phase_next  = (phase == PH_START1) ? PH_ADDR : PH_CMD;
                bits_next   = BITS_PER_GROUP;
                half_next   = 1'b0;
                levels_next = levels & ~cur_mask;
                time_next   = shift_bits[SHIFT_W-1] ? dur(cfg.short_time)
                                                    : dur(cfg.long_time);
              end
              PH_ADDR, PH_CMD: begin
                if (!half_cell) begin
                  half_next   = 1'b1;
                  levels_next = levels | cur_mask;
                  time_next   = shift_bits[SHIFT_W-1] ? dur(cfg.long_time)
                                                      : dur(cfg.short_time);
                end else begin
                  shift_next = shift_shl;
                  bits_next  = bits_dec;
                  if (bits_dec != '0) begin
                    half_next   = 1'b0;
                    levels_next = levels & ~cur_mask;
                    time_next   = shift_shl[SHIFT_W-1] ? dur(cfg.short_time)
                                                       : dur(cfg.long_time);
                  end else if (phase == PH_ADDR) begin
                    levels_next = levels & ~cur_mask;
                    phase_next  = PH_EOS;
                    time_next   = dur(cfg.end_time);
                  end else if (ack_requested) begin
                    // release the line so the device can pull it low
                    drives_next = drives & ~cur_mask;
                    phase_next  = PH_ACKWAIT;
                    time_next   = dur(cfg.end_time);
                  end else begin
                    levels_next = levels & ~cur_mask;
                    phase_next  = PH_STOP;
                    time_next   = dur(cfg.end_time);
                  end
                end
              end
              PH_EOS: begin
                levels_next = levels | cur_mask;
                phase_next  = PH_START2;
                time_next   = dur(cfg.start_time);
              end
              PH_ACKWAIT: begin
                ack_v      = 1'b1;
                ack_l      = s1_line_sample;
                phase_next = PH_ACKWIN;
                time_next  = dur(cfg.ack_window);
              end
              PH_ACKWIN: begin
                drives_next = drives | cur_mask;
                levels_next = levels | cur_mask;
                phase_next  = PH_IDLE;
                done_f      = 1'b1;
              end
              default: begin
                // stop phase: end-of-stream low is over, line back high
                levels_next = levels | cur_mask;
                phase_next  = PH_IDLE;
                done_f      = 1'b1;
              end
            endcase
          end
        end
      end
      ACT_SEND: begin
        if (busy || chan_bad) begin
          rej_f = 1'b1;
        end else begin
          line_next   = s1_channel;
          ackreq_next = s1_want_ack;
          shift_next  = {cfg.device_address, s1_want_ack, s1_reg_address, s1_data};
          drives_next = drives | send_mask;
          levels_next = levels | send_mask;
          phase_next  = PH_START1;
          time_next   = dur(cfg.start_time);
        end
      end
      ACT_INIT: begin
        if (busy) begin
          rej_f = 1'b1;
        end else begin
          drives_next = '1;
          levels_next = '1;
          phase_next  = PH_DHIGH;
          time_next   = dur(cfg.detect_high_time);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      phase         <= PH_IDLE;
      time_left     <= '0;
      bits_left     <= '0;
      half_cell     <= 1'b0;
      shift_bits    <= '0;
      active_line   <= '0;
      ack_requested <= 1'b0;
      levels        <= '0;
      drives        <= '1;
    end else begin
      if (in_ch.ready) s1_valid <= in_ch.valid;
      if (adv) begin
        out_valid     <= 1'b1;
        phase         <= phase_next;
        time_left     <= time_next;
        bits_left     <= bits_next;
        half_cell     <= half_next;
        shift_bits    <= shift_next;
        active_line   <= line_next;
        ack_requested <= ackreq_next;
        levels        <= levels_next;
        drives        <= drives_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_action      <= in_ch.action;
      s1_channel     <= in_ch.channel;
      s1_want_ack    <= in_ch.want_ack;
      s1_reg_address <= in_ch.reg_address;
      s1_data        <= in_ch.data;
      s1_line_sample <= in_ch.line_sample;
    end
    if (adv) begin
      res_levels <= LINES_W'(levels_next & drives_next);
      res_drives <= LINES_W'(drives_next);
      res_busy   <= (phase_next != PH_IDLE);
      res_done   <= done_f;
      res_ack_v  <= ack_v;
      res_ack_l  <= ack_l;
      res_rej    <= rej_f;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.line_levels = res_levels;
  assign out_ch.drive_mask  = res_drives;
  assign out_ch.busy_res    = res_busy;
  assign out_ch.done_res    = res_done;
  assign out_ch.ack_valid   = res_ack_v;
  assign out_ch.ack_level   = res_ack_l;
  assign out_ch.rejected    = res_rej;

endmodule

### hdl/single_wire_dimming_transmitter.sv
`timescale 1ns / 1ps

// Channel   | Dir | Handshake            | Word
// ----------+-----+----------------------+-----------------------------------------------
// in_ch     | in  | valid/ready          | action, channel, want_ack, reg_address, data,
//           |     |                      | line_sample
// out_ch    | out | valid/ready          | line_levels, drive_mask, busy_res, done_res,
//           |     |                      | ack_valid, ack_level, rejected
// APB       | in  | psel/penable, pready | 8 timing/address registers at 4*index
//
// One word per cycle sustained while out_ch is ready; each word is registered in the input
// stage, stepped through the sequencer and lands in the result register.
// The combinational sequencer update (timer decrement plus segment select) sets the rate.
// Synchronous active-high rst: idle phase, all lines driven low, registers to defaults.
// A stalled out_ch holds its word; the input stage fills and then drops in_ch.ready.

module single_wire_dimming_transmitter #(
  parameter int TIMER_WIDTH = swdt_pkg::TIMER_WIDTH_DEF,
  parameter int LINE_COUNT  = swdt_pkg::LINE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  swdt_in_if.sink                      in_ch,
  swdt_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swdt_pkg::PADDR_W-1:0] paddr,
  input  logic [swdt_pkg::PDATA_W-1:0] pwdata,
  output logic [swdt_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import swdt_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_wr;

  // Registers sit on 32-bit word boundaries; low address bits are ignored.
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address   <= RST_DEVICE_ADDRESS;
      cfg.start_time       <= RST_START_TIME;
      cfg.end_time         <= RST_END_TIME;
      cfg.short_time       <= RST_SHORT_TIME;
      cfg.long_time        <= RST_LONG_TIME;
      cfg.ack_window       <= RST_ACK_WINDOW;
      cfg.detect_high_time <= RST_DETECT_HIGH;
      cfg.detect_low_time  <= RST_DETECT_LOW;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DEVICE_ADDRESS: cfg.device_address   <= pwdata[DEV_W-1:0];
        REG_START_TIME:     cfg.start_time       <= pwdata[TIME_W-1:0];
        REG_END_TIME:       cfg.end_time         <= pwdata[TIME_W-1:0];
        REG_SHORT_TIME:     cfg.short_time       <= pwdata[TIME_W-1:0];
        REG_LONG_TIME:      cfg.long_time        <= pwdata[TIME_W-1:0];
        REG_ACK_WINDOW:     cfg.ack_window       <= pwdata[TIME_W-1:0];
        REG_DETECT_HIGH:    cfg.detect_high_time <= pwdata[TIME_W-1:0];
        REG_DETECT_LOW:     cfg.detect_low_time  <= pwdata[TIME_W-1:0];
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    unique case (reg_sel)
      REG_DEVICE_ADDRESS: prdata = PDATA_W'(cfg.device_address);
      REG_START_TIME:     prdata = PDATA_W'(cfg.start_time);
      REG_END_TIME:       prdata = PDATA_W'(cfg.end_time);
      REG_SHORT_TIME:     prdata = PDATA_W'(cfg.short_time);
      REG_LONG_TIME:      prdata = PDATA_W'(cfg.long_time);
      REG_ACK_WINDOW:     prdata = PDATA_W'(cfg.ack_window);
      REG_DETECT_HIGH:    prdata = PDATA_W'(cfg.detect_high_time);
      REG_DETECT_LOW:     prdata = PDATA_W'(cfg.detect_low_time);
    endcase
  end

  swdt_core #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .LINE_COUNT  (LINE_COUNT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // A released line never shows a driven level
  a_levels_driven: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ((out_ch.line_levels & ~out_ch.drive_mask) == '0))
    else $error("line level reported on a released line");

  // Finishing a sequence leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.done_res) |-> !out_ch.busy_res)
    else $error("done word still busy");

  // A refused command never advances a sequence
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.rejected) |-> (!out_ch.done_res && !out_ch.ack_valid))
    else $error("rejected word carries sequence events");

  // Acknowledge level only accompanies a sample, which happens mid-command
  a_ack_sample: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ack_level) |-> (out_ch.ack_valid && out_ch.busy_res))
    else $error("acknowledge level without a sample");

endmodule
